// ----- design/d96m_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, sequencer states and constants of the decimal 96-bit multiply core.
package d96m_pkg;

   localparam int LIMB_W      = 32;
   localparam int MAG_W       = 96;
   localparam int MAG_LOW_W   = 64;
   localparam int MAG_HIGH_W  = 32;
   localparam int PROD_W      = 192;
   localparam int SCALE_W     = 5;
   localparam int SUM_SCALE_W = 6;
   localparam int REM_W       = 4;
   localparam int RECIP_W     = 33;

   localparam logic [SUM_SCALE_W-1:0] MAX_SCALE = 6'd28;

   // floor(2**36 / 10): quotient estimate for a 36-bit dividend, low by at most one.
   localparam logic [RECIP_W-1:0] RECIP_TEN = 33'h1_9999_9999;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_OVF_POS = 2'd1;
   localparam logic [1:0] STATUS_OVF_NEG = 2'd2;

   typedef struct packed {
      logic [MAG_LOW_W-1:0]  a_mag_low;
      logic [MAG_HIGH_W-1:0] a_mag_high;
      logic [SCALE_W-1:0]    a_scale;
      logic                  a_negative;
      logic [MAG_LOW_W-1:0]  b_mag_low;
      logic [MAG_HIGH_W-1:0] b_mag_high;
      logic [SCALE_W-1:0]    b_scale;
      logic                  b_negative;
   } req_type;

   typedef struct packed {
      logic [MAG_LOW_W-1:0]  prod_mag_low;
      logic [MAG_HIGH_W-1:0] prod_mag_high;
      logic [SCALE_W-1:0]    prod_scale;
      logic                  prod_negative;
      logic [1:0]            status;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_CHECK,
      ST_DIV,
      ST_ROUND,
      ST_FINISH
   } state_type;

endpackage

// ----- design/d96m_mul_unit.sv -----
`timescale 1ns / 1ps
// Iterative 96 x 96 bit multiplier: one 32 x 32 partial product per cycle into a 192-bit sum.
module d96m_mul_unit import d96m_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [MAG_W-1:0]  x_in,
   input  logic [MAG_W-1:0]  y_in,
   output logic              done,
   output logic [PROD_W-1:0] product
);

   localparam logic [1:0] LAST_LIMB = 2'd2;

   logic                  run_ff, run_in;
   logic [1:0]            i_ff, i_in;
   logic [1:0]            j_ff, j_in;
   logic [2*LIMB_W-1:0]   pp_ff, pp_in;
   logic [2:0]            pp_pos_ff, pp_pos_in;
   logic                  pp_valid_ff, pp_valid_in;
   logic                  pp_last_ff, pp_last_in;
   logic [PROD_W-1:0]     acc_ff, acc_in;
   logic [PROD_W-1:0]     addend;
   logic                  done_ff, done_in;

   function automatic logic [LIMB_W-1:0] limb_of(input logic [MAG_W-1:0] v,
                                                 input logic [1:0] idx);
      logic [LIMB_W-1:0] r;
      case (idx)
         2'd0:    r = v[LIMB_W-1:0];
         2'd1:    r = v[2*LIMB_W-1:LIMB_W];
         2'd2:    r = v[3*LIMB_W-1:2*LIMB_W];
         default: r = '0;
      endcase
      return r;
   endfunction

   // Issue side: walk the nine limb pairs, one multiplication per cycle.
   always_comb begin
      run_in      = run_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      pp_in       = pp_ff;
      pp_pos_in   = pp_pos_ff;
      pp_valid_in = 1'b0;
      pp_last_in  = 1'b0;
      if (start) begin
         run_in = 1'b1;
         i_in   = 2'd0;
         j_in   = 2'd0;
      end else if (run_ff) begin
         pp_in       = limb_of(x_in, i_ff) * limb_of(y_in, j_ff);
         pp_pos_in   = {1'b0, i_ff} + {1'b0, j_ff};
         pp_valid_in = 1'b1;
         if (j_ff == LAST_LIMB) begin
            j_in = 2'd0;
            if (i_ff == LAST_LIMB) begin
               run_in     = 1'b0;
               pp_last_in = 1'b1;
            end else begin
               i_in = i_ff + 2'd1;
            end
         end else begin
            j_in = j_ff + 2'd1;
         end
      end
   end

   // Accumulate side: the registered partial product lands at its limb position.
   assign addend = {{(PROD_W-2*LIMB_W){1'b0}}, pp_ff} << {pp_pos_ff, 5'b0};

   always_comb begin
      if (start) begin
         acc_in = '0;
      end else if (pp_valid_ff) begin
         acc_in = acc_ff + addend;
      end else begin
         acc_in = acc_ff;
      end
   end

   assign done_in = pp_valid_ff & pp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         i_ff        <= 2'd0;
         j_ff        <= 2'd0;
         pp_valid_ff <= 1'b0;
         pp_last_ff  <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         run_ff      <= run_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         pp_valid_ff <= pp_valid_in;
         pp_last_ff  <= pp_last_in;
         done_ff     <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      pp_ff     <= pp_in;
      pp_pos_ff <= pp_pos_in;
      acc_ff    <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

// ----- design/d96m_div10_unit.sv -----
`timescale 1ns / 1ps
// One long-division step by ten on a 32-bit limb with the running remainder.
module d96m_div10_unit import d96m_pkg::*; (
   input  logic [REM_W-1:0]  rem_in,
   input  logic [LIMB_W-1:0] limb_in,
   output logic [LIMB_W-1:0] quot_out,
   output logic [REM_W-1:0]  rem_out
);

   localparam int CUR_W = LIMB_W + REM_W;

   logic [CUR_W-1:0]         cur;
   logic [CUR_W+RECIP_W-1:0] est;
   logic [LIMB_W-1:0]        q_est;
   logic [4:0]               r_est;
   logic [4:0]               r_fix;
   logic                     fix;

   assign cur   = {rem_in, limb_in};
   assign est   = {{RECIP_W{1'b0}}, cur} * {{CUR_W{1'b0}}, RECIP_TEN};
   assign q_est = est[CUR_W +: LIMB_W];

   // The remainder is below twenty, so only its low five bits need forming:
   // cur - 10 * q_est, with 10 * q = 2 * q + 8 * q.
   assign r_est = cur[4:0] - {q_est[3:0], 1'b0} - {q_est[1:0], 3'b0};
   assign r_fix = r_est - 5'd10;
   assign fix   = (r_est >= 5'd10);

   assign quot_out = q_est + {{(LIMB_W-1){1'b0}}, fix};
   assign rem_out  = fix ? r_fix[REM_W-1:0] : r_est[REM_W-1:0];

endmodule

// ----- design/decimal96_multiply_core.sv -----
`timescale 1ns / 1ps
// Top level of the decimal 96-bit multiply core: sequencer, working register and result stage.
//
// The core multiplies two scaled decimal numbers, each a 96-bit magnitude, a sign and a
// power-of-ten scale, and returns the product in the same form. One request beat is taken
// at a time. The 192-bit product is built by a single 32 x 32 multiplier over the nine
// limb pairs. The core then checks the product: while it is wider than 96 bits or its
// scale is above 28, and the scale is above zero, it divides by ten with round half to
// even and lowers the scale by one. Each such division walks the six 32-bit limbs through
// one shared divide-by-ten unit, one limb per cycle, then rounds and checks again. The
// next request beat can be taken once the result has moved into the response register, at
// the earliest. The number of divisions is zero for products that fit in 96 bits with a
// summed scale of at most 28, and at most the summed scale.
// If the product still does not fit once the scale reaches zero, the response carries a
// zero magnitude, zero scale and zero sign, with status reporting overflow by the sign of
// the product. A zero product keeps the XOR of the operand signs, so a negative zero can
// come out. The response sits in an output register, so the next request beat is taken
// while an earlier response still waits on rsp_stall.
module decimal96_multiply_core import d96m_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [2:0] TOP_LIMB = 3'd5;
   localparam logic [3:0] HALF     = 4'd5;

   state_type               state_ff, state_in;
   logic [MAG_W-1:0]        x_ff, x_in;
   logic [MAG_W-1:0]        y_ff, y_in;
   logic                    neg_ff, neg_in;
   logic [SUM_SCALE_W-1:0]  scale_ff, scale_in;
   logic [PROD_W-1:0]       work_ff, work_in;
   logic [2:0]              limb_ff, limb_in;
   logic [REM_W-1:0]        rem_ff, rem_in;
   rsp_type                 rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   logic                    req_accept;
   logic                    rsp_free;
   logic                    mul_start;
   logic                    mul_done;
   logic [PROD_W-1:0]       mul_product;
   logic                    too_wide;
   logic                    need_div;
   logic [LIMB_W-1:0]       div_limb;
   logic [LIMB_W-1:0]       div_quot;
   logic [REM_W-1:0]        div_rem;
   logic                    round_up;
   logic                    load_op;
   logic                    load_work;
   logic                    start_div;
   logic                    div_step;
   logic                    round_step;
   logic                    load_rsp;

   d96m_mul_unit u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .x_in    (x_ff),
      .y_in    (y_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   d96m_div10_unit u_div10 (
      .rem_in   (rem_ff),
      .limb_in  (div_limb),
      .quot_out (div_quot),
      .rem_out  (div_rem)
   );

   // Handshake terms.
   assign req_accept = req_valid & ~req_stall;
   assign rsp_free   = ~rsp_valid_ff | ~rsp_stall;

   // Status of the working product.
   assign too_wide = |work_ff[PROD_W-1:MAG_W];
   assign need_div = (too_wide || (scale_ff > MAX_SCALE)) && (scale_ff != '0);
   assign div_limb = work_ff[{limb_ff, 5'b0} +: LIMB_W];
   assign round_up = (rem_ff > HALF) || ((rem_ff == HALF) && work_ff[0]);

   // Next state of the sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (need_div) begin
               state_in = ST_DIV;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_DIV: begin
            if (limb_ff == '0) begin
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            state_in = ST_CHECK;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_stall  = 1'b1;
      load_op    = 1'b0;
      mul_start  = 1'b0;
      load_work  = 1'b0;
      start_div  = 1'b0;
      div_step   = 1'b0;
      round_step = 1'b0;
      load_rsp   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            load_op   = req_valid;
            mul_start = req_valid;
         end
         ST_MUL: begin
            load_work = mul_done;
         end
         ST_CHECK: begin
            start_div = need_div;
         end
         ST_DIV: begin
            div_step = 1'b1;
         end
         ST_ROUND: begin
            round_step = 1'b1;
         end
         ST_FINISH: begin
            load_rsp = rsp_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Operand registers, taken with the request beat.
   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      neg_in   = neg_ff;
      if (load_op) begin
         x_in   = {req_data.a_mag_high, req_data.a_mag_low};
         y_in   = {req_data.b_mag_high, req_data.b_mag_low};
         neg_in = req_data.a_negative ^ req_data.b_negative;
      end
   end

   // Working product, scale, limb pointer and running remainder.
   always_comb begin
      work_in  = work_ff;
      scale_in = scale_ff;
      limb_in  = limb_ff;
      rem_in   = rem_ff;
      if (load_op) begin
         scale_in = {1'b0, req_data.a_scale} + {1'b0, req_data.b_scale};
      end
      if (load_work) begin
         work_in = mul_product;
      end
      if (start_div) begin
         limb_in = TOP_LIMB;
         rem_in  = '0;
      end
      if (div_step) begin
         work_in[{limb_ff, 5'b0} +: LIMB_W] = div_quot;
         rem_in  = div_rem;
         limb_in = limb_ff - 3'd1;
      end
      if (round_step) begin
         work_in  = work_ff + {{(PROD_W-1){1'b0}}, round_up};
         scale_in = scale_ff - 6'd1;
      end
   end

   // Response register: an overflow clears every field but the status.
   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         if (too_wide) begin
            rsp_in.prod_mag_low  = '0;
            rsp_in.prod_mag_high = '0;
            rsp_in.prod_scale    = '0;
            rsp_in.prod_negative = 1'b0;
            rsp_in.status        = neg_ff ? STATUS_OVF_NEG : STATUS_OVF_POS;
         end else begin
            rsp_in.prod_mag_low  = work_ff[MAG_LOW_W-1:0];
            rsp_in.prod_mag_high = work_ff[MAG_W-1:MAG_LOW_W];
            rsp_in.prod_scale    = scale_ff[SCALE_W-1:0];
            rsp_in.prod_negative = neg_ff;
            rsp_in.status        = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         limb_ff      <= '0;
         rem_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         limb_ff      <= limb_in;
         rem_ff       <= rem_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      neg_ff   <= neg_in;
      scale_ff <= scale_in;
      work_ff  <= work_in;
      rsp_ff   <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   // The reduction loop always leaves the scale within range.
   a_scale_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (scale_ff <= MAX_SCALE))
      else $error("scale above limit when the result is formed");

   // The running remainder of the division by ten stays a decimal digit.
   a_rem_digit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV || state_ff == ST_ROUND) |-> (rem_ff < 4'd10))
      else $error("division remainder is not a decimal digit");

   // The multiplier only finishes while the sequencer waits for it.
   a_mul_done_in_mul: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (state_ff == ST_MUL))
      else $error("multiplier finished outside the multiply phase");

   // A new response only appears straight after the finish phase.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response raised outside the finish phase");
`endif

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench of the decimal 96-bit multiply core with its own product predictor.
module testbench;
   import d96m_pkg::*;

   // The run is bounded by a watchdog. The bound allows for every request needing the
   // largest number of divide-by-ten steps, for random stalls on both sides and for the
   // long receiver hold-off, several times over.
   localparam int unsigned CYCLE_LIMIT      = 4_000_000;
   localparam int unsigned RESET_CYCLES     = 9;
   localparam int unsigned ITEMS_PER_PHASE  = 434;
   localparam int unsigned LONG_HOLD_CYCLES = 4000;
   // This settle time covers even the slowest request, with 62 divide-by-ten steps.
   localparam int unsigned SETTLE_CYCLES    = 600;
   localparam int unsigned REPORT_LIMIT     = 10;
   localparam logic [MAG_W-1:0] ALL_ONES    = '1;
   localparam int unsigned TEN              = 10;
   localparam int unsigned HALF_DIGIT       = 5;

   // The scoreboard keeps the products that the core still owes us, oldest first, and
   // works each one out when its request beat is accepted.
   class product_scoreboard;
      rsp_type     expected_products[$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
      endfunction

      // Exact 192-bit product, then the scale reduction: each step divides by ten and
      // rounds half to even on its own, so a long reduction can round more than once.
      function rsp_type predict_product(req_type beat);
         logic [PROD_W-1:0]      wide;
         logic [PROD_W-1:0]      quot;
         logic [PROD_W-1:0]      lhs;
         logic [PROD_W-1:0]      rhs;
         logic [3:0]             digit;
         logic [SUM_SCALE_W-1:0] scale;
         logic                   negative;
         rsp_type                product;

         lhs      = {96'd0, beat.a_mag_high, beat.a_mag_low};
         rhs      = {96'd0, beat.b_mag_high, beat.b_mag_low};
         wide     = lhs * rhs;
         scale    = {1'b0, beat.a_scale} + {1'b0, beat.b_scale};
         negative = beat.a_negative ^ beat.b_negative;

         while ((wide[PROD_W-1:MAG_W] != '0 || scale > MAX_SCALE) && scale != '0) begin
            quot  = wide / TEN;
            digit = 4'(wide % TEN);
            if (digit > HALF_DIGIT || (digit == HALF_DIGIT && quot[0])) begin
               quot = quot + 1'b1;
            end
            wide  = quot;
            scale = scale - 1'b1;
         end

         product = '0;
         if (wide[PROD_W-1:MAG_W] != '0) begin
            product.status = negative ? STATUS_OVF_NEG : STATUS_OVF_POS;
         end else begin
            product.prod_mag_low  = wide[MAG_LOW_W-1:0];
            product.prod_mag_high = wide[MAG_W-1:MAG_LOW_W];
            product.prod_scale    = scale[SCALE_W-1:0];
            product.prod_negative = negative;
            product.status        = STATUS_OK;
         end
         return product;
      endfunction

      function void note_request(req_type beat);
         expected_products.push_back(predict_product(beat));
      endfunction

      function void check_result(rsp_type actual);
         rsp_type wanted;

         if (expected_products.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
               $display("error: response beat with no product outstanding: %h", actual);
            end
         end else begin
            wanted = expected_products.pop_front();
            if (actual.prod_mag_low  !== wanted.prod_mag_low  ||
                actual.prod_mag_high !== wanted.prod_mag_high ||
                actual.prod_scale    !== wanted.prod_scale    ||
                actual.prod_negative !== wanted.prod_negative ||
                actual.status        !== wanted.status) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT) begin
                  $display("error: expected mag %h_%h scale %0d neg %b status %0d",
                           wanted.prod_mag_high, wanted.prod_mag_low, wanted.prod_scale,
                           wanted.prod_negative, wanted.status);
                  $display("       actual   mag %h_%h scale %0d neg %b status %0d",
                           actual.prod_mag_high, actual.prod_mag_low, actual.prod_scale,
                           actual.prod_negative, actual.status);
               end
            end
         end
      endfunction

      function int unsigned outstanding();
         return expected_products.size();
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   // Idle rates in percent for each side; the main sequence changes them between phases.
   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;
   logic        hold_armed;
   logic        long_hold;
   int unsigned cycle_count = 0;

   product_scoreboard products = new();

   decimal96_multiply_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Watchdog: a hung core or a lost response must not let the run go on for ever.
   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // Response side. Outputs are sampled at the edge, before any register of the core has
   // moved, and a beat counts only when our own stall was low going into that edge. The
   // stall is then chosen afresh for the next cycle, or held high during the long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            products.check_result(rsp_data);
         end
         rsp_stall <= long_hold || ($urandom_range(99) < rsp_idle_pct);
      end
   end

   // The long hold-off is timed here on its own, so the request side keeps offering beats
   // meanwhile. The core holds only one request and one finished response, so it soon has
   // to stall its request side until the hold-off ends.
   initial begin
      long_hold = 1'b0;
      wait (hold_armed);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clock);
      long_hold <= 1'b0;
   end

   function automatic logic [MAG_W-1:0] ten_power(int unsigned exponent);
      logic [MAG_W-1:0] power;

      power = 1;
      repeat (exponent) power = power * TEN;
      return power;
   endfunction

   // Magnitudes come from several families: full width, random lengths, small values,
   // values next to all ones and values next to a power of ten.
   function automatic logic [MAG_W-1:0] random_magnitude();
      logic [MAG_W-1:0] mag;
      int unsigned      family;

      family = $urandom_range(9);
      mag    = {$urandom, $urandom, $urandom};
      case (family)
         4: begin
            mag = mag >> $urandom_range(95);
         end
         5: begin
            mag = {64'd0, mag[31:0]};
         end
         6: begin
            mag = MAG_W'($urandom_range(1000));
         end
         7: begin
            mag = ALL_ONES - $urandom_range(3);
         end
         8: begin
            mag = ten_power($urandom_range(28)) - 1 + $urandom_range(2);
         end
         9: begin
            mag = mag >> $urandom_range(70, 40);
         end
         default: begin
         end
      endcase
      return mag;
   endfunction

   // Mostly legal scales, with the occasional out-of-range one that the core must still
   // reduce to 28 or below.
   function automatic logic [SCALE_W-1:0] random_scale();
      if ($urandom_range(9) == 0) begin
         return SCALE_W'($urandom_range(31, 29));
      end
      return SCALE_W'($urandom_range(28));
   endfunction

   // Offers one request beat and returns once it has been taken. Valid is left high, so a
   // following beat can go out back to back; it only drops when the sender idles.
   task automatic send_beat(req_type beat);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      products.note_request(beat);
   endtask

   task automatic send_operands(logic [MAG_W-1:0] a_mag, logic [SCALE_W-1:0] a_scale,
                                logic a_negative, logic [MAG_W-1:0] b_mag,
                                logic [SCALE_W-1:0] b_scale, logic b_negative);
      req_type beat;

      beat.a_mag_low  = a_mag[MAG_LOW_W-1:0];
      beat.a_mag_high = a_mag[MAG_W-1:MAG_LOW_W];
      beat.a_scale    = a_scale;
      beat.a_negative = a_negative;
      beat.b_mag_low  = b_mag[MAG_LOW_W-1:0];
      beat.b_mag_high = b_mag[MAG_W-1:MAG_LOW_W];
      beat.b_scale    = b_scale;
      beat.b_negative = b_negative;
      send_beat(beat);
   endtask

   // A rounding tie: a small magnitude ending in five, with a summed scale just over 28, so
   // that one or a few divide-by-ten steps land exactly on a half.
   task automatic send_rounding_tie();
      logic [SUM_SCALE_W-1:0] total;
      logic [SCALE_W-1:0]     a_scale;

      total   = SUM_SCALE_W'(29 + $urandom_range(2));
      a_scale = SCALE_W'($urandom_range(28, 3));
      send_operands(MAG_W'($urandom_range(100000) * TEN + HALF_DIGIT), a_scale,
                    1'($urandom_range(1)), 1, SCALE_W'(total - a_scale),
                    1'($urandom_range(1)));
   endtask

   task automatic send_random_items(int unsigned count);
      repeat (count) begin
         if ($urandom_range(11) == 0) begin
            send_rounding_tie();
         end else begin
            send_operands(random_magnitude(), random_scale(), 1'($urandom_range(1)),
                          random_magnitude(), random_scale(), 1'($urandom_range(1)));
         end
      end
   endtask

   // Pauses the sender until every outstanding product has come back.
   task automatic drain_products();
      req_valid <= 1'b0;
      while (products.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_data     = '0;
      req_idle_pct = 16;
      rsp_idle_pct = 60;
      hold_armed   = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed beats: zero and negative zero, the extremes of magnitude and scale, both
      // overflow signs, exact fits, and rounding ties going down to even and up to even.
      send_operands(0, 0, 1'b0, 0, 0, 1'b0);
      send_operands(0, 0, 1'b1, 0, 5, 1'b0);
      send_operands(1, 28, 1'b1, 1, 0, 1'b1);
      send_operands(ALL_ONES, 0, 1'b0, ALL_ONES, 0, 1'b0);
      send_operands(ALL_ONES, 0, 1'b1, ALL_ONES, 0, 1'b0);
      send_operands(ALL_ONES, 28, 1'b1, ALL_ONES, 28, 1'b1);
      send_operands(ALL_ONES, 31, 1'b0, 1, 31, 1'b1);
      send_operands(ALL_ONES, 0, 1'b0, 1, 0, 1'b1);
      send_operands(ALL_ONES, 1, 1'b0, 2, 0, 1'b0);
      send_operands(ALL_ONES, 0, 1'b0, 2, 0, 1'b0);
      send_operands(96'd1 << 48, 0, 1'b0, 96'd1 << 48, 0, 1'b1);
      send_operands(96'd1 << 48, 1, 1'b0, 96'd1 << 48, 0, 1'b0);
      send_operands(ten_power(28), 28, 1'b0, ten_power(28), 28, 1'b1);
      send_operands(ten_power(28), 0, 1'b1, 1, 0, 1'b0);
      send_operands({32'hFFFF_FFFF, 64'd0}, 29, 1'b0, {32'd0, 64'hFFFF_FFFF_FFFF_FFFF},
                    30, 1'b0);
      send_operands(25, 15, 1'b0, 1, 14, 1'b0);
      send_operands(35, 15, 1'b1, 1, 14, 1'b0);
      send_operands(24, 15, 1'b0, 1, 14, 1'b0);
      send_operands(26, 15, 1'b0, 1, 14, 1'b1);
      send_operands(15, 1, 1'b0, 1, 30, 1'b0);
      send_operands(ALL_ONES - 1, 31, 1'b1, ALL_ONES - 2, 31, 1'b0);

      // First phase: the sender idles a little and the receiver a lot. Part way through,
      // the receiver holds off for a long stretch while beats keep being offered.
      send_random_items(ITEMS_PER_PHASE / 4);
      hold_armed = 1'b1;
      send_random_items(ITEMS_PER_PHASE - ITEMS_PER_PHASE / 4);
      drain_products();

      // Second phase: the roles swap.
      req_idle_pct = 60;
      rsp_idle_pct = 16;
      send_random_items(ITEMS_PER_PHASE);
      drain_products();

      // Last phase: no idling on either side, beats back to back.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      send_random_items(ITEMS_PER_PHASE);
      drain_products();

      // Any stray response beat arriving late is caught by the response side meanwhile.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (products.mismatches == 0 && products.outstanding() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
